### hdl/ppnf_pkg.sv
// ----------------------------------------------------------------------------
// ppnf_pkg
// Shared types and constants of the particle pool with next-fit allocation.
// ----------------------------------------------------------------------------
package ppnf_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_OUT_W = 6;
  localparam int LIFE_W     = 16;
  localparam int RATE_W     = 16;
  localparam int DT_W       = 16;
  localparam int LOSS_SHIFT = 9;
  localparam int LOSS_W     = RATE_W + DT_W - LOSS_SHIFT;

  localparam logic [LIFE_W-1:0] LIFE_FULL  = 16'd32768;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_LIST = 2'd2;

  typedef enum logic [1:0] {
    KIND_ASSIGNED = 2'd0,
    KIND_TICK     = 2'd1,
    KIND_LIVE     = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_INPUT = 2'd1,
    SRC_PEND  = 2'd2
  } res_src_t;

  typedef struct packed {
    logic     capture;
    logic     scan_start;
    logic     scan_zero;
    logic     scan_next;
    logic     sel_zero;
    logic     loss_load;
    logic     life_decay;
    logic     add_write;
    logic     add_found;
    logic     pend_load;
    logic     res_load;
    kind_t    res_kind;
    res_src_t res_src;
    logic     res_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic live;
    logic idx_end;
    logic step_end;
    logic out_free;
  } dp_status_t;

endpackage

### hdl/ppnf_req_if.sv
// ----------------------------------------------------------------------------
// ppnf_req_if
// Request channel: command and new particle record, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppnf_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  command;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic        [31:0] rgba;
  logic        [31:0] size;
  logic        [15:0] delta_time;

  modport source (
    output valid, command, pos_x, pos_y, vel_x, vel_y, rgba, size, delta_time,
    input  ready
  );
  modport sink (
    input  valid, command, pos_x, pos_y, vel_x, vel_y, rgba, size, delta_time,
    output ready
  );
endinterface

### hdl/ppnf_resp_if.sv
// ----------------------------------------------------------------------------
// ppnf_resp_if
// Result channel: slot reports and completions, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppnf_resp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic        [5:0]  slot;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic        [31:0] out_size;
  logic        [31:0] out_rgba;
  logic        [15:0] life_left;
  logic               last;

  modport source (
    output valid, kind, slot, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
           out_size, out_rgba, life_left, last,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
           out_size, out_rgba, life_left, last,
    output ready
  );
endinterface

### hdl/ppnf_ctrl.sv
// ----------------------------------------------------------------------------
// ppnf_ctrl
// Add/tick/list sequencer; drives the datapath one slot per cycle unless stalled.
// ----------------------------------------------------------------------------
module ppnf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             in_command,
  output logic                   in_ready,
  input  ppnf_pkg::dp_status_t   status,
  output ppnf_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_ADD_SCAN  = 8'b0000_0010,
    S_ADD_WRITE = 8'b0000_0100,
    S_TICK_MUL  = 8'b0000_1000,
    S_TICK_SCAN = 8'b0001_0000,
    S_TICK_DONE = 8'b0010_0000,
    S_LIST_SCAN = 8'b0100_0000,
    S_LIST_END  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   found, found_next;
  logic   have_pend, have_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      found     <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      state     <= state_next;
      found     <= found_next;
      have_pend <= have_pend_next;
    end
  end

  always_comb begin
    state_next     = state;
    found_next     = found;
    have_pend_next = have_pend;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.res_kind   = ppnf_pkg::KIND_NONE;
    cmd.res_src    = ppnf_pkg::SRC_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_command)
            ppnf_pkg::CMD_ADD: begin
              cmd.scan_start = 1'b1;
              state_next     = S_ADD_SCAN;
            end
            ppnf_pkg::CMD_TICK: begin
              state_next = S_TICK_MUL;
            end
            ppnf_pkg::CMD_LIST: begin
              cmd.scan_zero  = 1'b1;
              have_pend_next = 1'b0;
              state_next     = S_LIST_SCAN;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (!status.live) begin
          found_next = 1'b1;
          state_next = S_ADD_WRITE;
        end else if (status.step_end) begin
          // pool full: fall back to slot zero
          cmd.sel_zero = 1'b1;
          found_next   = 1'b0;
          state_next   = S_ADD_WRITE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_ADD_WRITE: begin
        if (status.out_free) begin
          cmd.add_write = 1'b1;
          cmd.add_found = found;
          cmd.res_load  = 1'b1;
          cmd.res_kind  = ppnf_pkg::KIND_ASSIGNED;
          cmd.res_src   = ppnf_pkg::SRC_INPUT;
          cmd.res_last  = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_TICK_MUL: begin
        cmd.loss_load = 1'b1;
        cmd.scan_zero = 1'b1;
        state_next    = S_TICK_SCAN;
      end
      S_TICK_SCAN: begin
        cmd.life_decay = 1'b1;
        if (status.idx_end) begin
          state_next = S_TICK_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_TICK_DONE: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = ppnf_pkg::KIND_TICK;
          cmd.res_src  = ppnf_pkg::SRC_NONE;
          cmd.res_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_LIST_SCAN: begin
        // one live record is held back until the next one shows whether it is last
        if (status.live && have_pend && !status.out_free) begin
          state_next = S_LIST_SCAN;
        end else begin
          if (status.live) begin
            cmd.pend_load  = 1'b1;
            have_pend_next = 1'b1;
            if (have_pend) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = ppnf_pkg::KIND_LIVE;
              cmd.res_src  = ppnf_pkg::SRC_PEND;
              cmd.res_last = 1'b0;
            end
          end
          if (status.idx_end) begin
            state_next = S_LIST_END;
          end else begin
            cmd.scan_next = 1'b1;
          end
        end
      end
      S_LIST_END: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_last = 1'b1;
          if (have_pend) begin
            cmd.res_kind = ppnf_pkg::KIND_LIVE;
            cmd.res_src  = ppnf_pkg::SRC_PEND;
          end else begin
            cmd.res_kind = ppnf_pkg::KIND_NONE;
            cmd.res_src  = ppnf_pkg::SRC_NONE;
          end
          have_pend_next = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/ppnf_datapath.sv
// ----------------------------------------------------------------------------
// ppnf_datapath
// Slot stores, lifetime registers, scan index, decay product and result register.
// ----------------------------------------------------------------------------
module ppnf_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata,
  input  logic signed [31:0]     in_pos_x,
  input  logic signed [31:0]     in_pos_y,
  input  logic signed [31:0]     in_vel_x,
  input  logic signed [31:0]     in_vel_y,
  input  logic [31:0]            in_rgba,
  input  logic [31:0]            in_size,
  input  logic [15:0]            in_delta_time,
  input  ppnf_pkg::ctrl_cmd_t    cmd,
  output ppnf_pkg::dp_status_t   status,
  ppnf_resp_if.source            resp
);

  localparam int SW = ppnf_pkg::SLOT_W;
  localparam int SN = ppnf_pkg::SLOT_COUNT;
  localparam int LW = ppnf_pkg::LIFE_W;
  localparam logic [SW-1:0] IDX_LAST = SW'(SN - 1);

  logic [ppnf_pkg::RATE_W-1:0] decay_rate;
  logic [ppnf_pkg::LOSS_W-1:0] loss;
  logic [SW-1:0]               idx;
  logic [SW-1:0]               step;
  logic [SW-1:0]               search_start;
  logic [LW-1:0]               life [SN];

  logic signed [31:0] cap_pos_x, cap_pos_y, cap_vel_x, cap_vel_y;
  logic [31:0]        cap_rgba, cap_size;
  logic [15:0]        cap_delta_time;

  logic [63:0] pos_mem  [SN];
  logic [63:0] vel_mem  [SN];
  logic [63:0] look_mem [SN];

  logic [63:0]   pend_pos, pend_vel, pend_look;
  logic [SW-1:0] pend_slot;
  logic [LW-1:0] pend_life;

  logic [LW-1:0]                life_cur;
  logic [LW-1:0]                life_sat;
  logic [ppnf_pkg::RATE_W+ppnf_pkg::DT_W-1:0] product;
  logic                         res_valid;

  assign life_cur = life[idx];
  assign product  = decay_rate * cap_delta_time;
  assign life_sat = ({{(ppnf_pkg::LOSS_W - LW){1'b0}}, life_cur} <= loss) ?
                    '0 : (life_cur - loss[LW-1:0]);

  assign status.live     = (life_cur != '0);
  assign status.idx_end  = (idx == IDX_LAST);
  assign status.step_end = (step == IDX_LAST);
  assign status.out_free = !res_valid || resp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate <= ppnf_pkg::RATE_RESET;
    end else if (cfg_we) begin
      decay_rate <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_pos_x      <= in_pos_x;
      cap_pos_y      <= in_pos_y;
      cap_vel_x      <= in_vel_x;
      cap_vel_y      <= in_vel_y;
      cap_rgba       <= in_rgba;
      cap_size       <= in_size;
      cap_delta_time <= in_delta_time;
    end
    if (cmd.loss_load) begin
      loss <= product[ppnf_pkg::RATE_W+ppnf_pkg::DT_W-1:ppnf_pkg::LOSS_SHIFT];
    end
  end

  // scan index and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      step <= '0;
    end else if (cmd.scan_start) begin
      idx  <= search_start;
      step <= '0;
    end else if (cmd.scan_zero || cmd.sel_zero) begin
      idx  <= '0;
      step <= '0;
    end else if (cmd.scan_next) begin
      idx  <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_start <= '0;
    end else if (cmd.add_write && cmd.add_found) begin
      search_start <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SN; i++) begin
        life[i] <= '0;
      end
    end else if (cmd.add_write) begin
      life[idx] <= ppnf_pkg::LIFE_FULL;
    end else if (cmd.life_decay) begin
      life[idx] <= life_sat;
    end
  end

  // record stores
  always_ff @(posedge clk) begin
    if (cmd.add_write) begin
      pos_mem[idx]  <= {cap_pos_y, cap_pos_x};
      vel_mem[idx]  <= {cap_vel_y, cap_vel_x};
      look_mem[idx] <= {cap_rgba, cap_size};
    end
    if (cmd.pend_load) begin
      pend_pos  <= pos_mem[idx];
      pend_vel  <= vel_mem[idx];
      pend_look <= look_mem[idx];
      pend_slot <= idx;
      pend_life <= life_cur;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (resp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      resp.kind <= cmd.res_kind;
      resp.last <= cmd.res_last;
      case (cmd.res_src)
        ppnf_pkg::SRC_INPUT: begin
          resp.slot      <= ppnf_pkg::SLOT_OUT_W'(idx);
          resp.out_pos_x <= cap_pos_x;
          resp.out_pos_y <= cap_pos_y;
          resp.out_vel_x <= cap_vel_x;
          resp.out_vel_y <= cap_vel_y;
          resp.out_size  <= cap_size;
          resp.out_rgba  <= cap_rgba;
          resp.life_left <= ppnf_pkg::LIFE_FULL;
        end
        ppnf_pkg::SRC_PEND: begin
          resp.slot      <= ppnf_pkg::SLOT_OUT_W'(pend_slot);
          resp.out_pos_x <= pend_pos[31:0];
          resp.out_pos_y <= pend_pos[63:32];
          resp.out_vel_x <= pend_vel[31:0];
          resp.out_vel_y <= pend_vel[63:32];
          resp.out_size  <= pend_look[31:0];
          resp.out_rgba  <= pend_look[63:32];
          resp.life_left <= pend_life;
        end
        default: begin
          resp.slot      <= '0;
          resp.out_pos_x <= '0;
          resp.out_pos_y <= '0;
          resp.out_vel_x <= '0;
          resp.out_vel_y <= '0;
          resp.out_size  <= '0;
          resp.out_rgba  <= '0;
          resp.life_left <= '0;
        end
      endcase
    end
  end

  assign resp.valid = res_valid;

endmodule

### hdl/particle_pool_next_fit_lifetime.sv
// ----------------------------------------------------------------------------
// particle_pool_next_fit_lifetime
// Particle slot pool: next-fit add, lifetime decay tick, list of live slots.
// ----------------------------------------------------------------------------
//   port       dir   handshake        payload
//   req        in    valid / ready    command, new record, delta_time
//   resp       out   valid / ready    kind, slot, record, life_left, last
//   cfg_we     in    write enable     cfg_wdata = decay_rate (Q8.8)
//
// every request is accepted in idle; command 3 does nothing more
// add: probes slots one by one from the remembered position (up to 32), then writes
// tick: forms the decay product, updates all 32 slots, then reports done
// list: scans all 32 slots, then gives the final result
// reset clears all lifetimes, the search position and the result register
// a stalled result register holds the controller until it drains
module particle_pool_next_fit_lifetime (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  ppnf_req_if.sink    req,
  ppnf_resp_if.source resp
);

  ppnf_pkg::ctrl_cmd_t  cmd;
  ppnf_pkg::dp_status_t status;

  ppnf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (req.ready),
    .status     (status),
    .cmd        (cmd)
  );

  ppnf_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_pos_x      (req.pos_x),
    .in_pos_y      (req.pos_y),
    .in_vel_x      (req.vel_x),
    .in_vel_y      (req.vel_y),
    .in_rgba       (req.rgba),
    .in_size       (req.size),
    .in_delta_time (req.delta_time),
    .cmd           (cmd),
    .status        (status),
    .resp          (resp)
  );

endmodule

### bench/tb_particle_pool_next_fit_lifetime.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_pool_next_fit_lifetime
// Self-checking bench for the particle pool. A behavioral copy of the pool
// works out every result from each accepted request. Results are checked in
// order, field by field. Requests go out in bursts with random gaps, and the
// result side stalls at random. The run covers an empty pool, exact and
// saturating lifetime decay, a full pool, the ignored command and decay
// rates from zero to full scale.
// ----------------------------------------------------------------------------
module tb_particle_pool_next_fit_lifetime;
  import ppnf_pkg::*;

  localparam logic [1:0]  CMD_IGNORED   = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] rgba;
    logic [31:0] size;
    logic [15:0] delta_time;
  } request_t;

  typedef struct {
    kind_t       kind;
    logic [5:0]  slot;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] size;
    logic [31:0] rgba;
    logic [15:0] life;
    logic        last;
  } particle_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  ppnf_req_if  req_ch ();
  ppnf_resp_if resp_ch ();

  particle_pool_next_fit_lifetime dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .resp      (resp_ch)
  );

  // pool model
  logic [15:0] pool_life  [SLOT_COUNT];
  logic [31:0] pool_pos_x [SLOT_COUNT];
  logic [31:0] pool_pos_y [SLOT_COUNT];
  logic [31:0] pool_vel_x [SLOT_COUNT];
  logic [31:0] pool_vel_y [SLOT_COUNT];
  logic [31:0] pool_rgba  [SLOT_COUNT];
  logic [31:0] pool_size  [SLOT_COUNT];
  int unsigned next_fit_pos;
  logic [15:0] decay_rate_now;

  request_t         pending_reqs [$];
  particle_result_t expected_results [$];

  int unsigned issued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  request_t    req_item;
  bit          req_taken  = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  int unsigned stall_left = 0;
  int unsigned stall_pct  = 0;
  int unsigned mode_left  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic particle_result_t slot_record(kind_t k, int unsigned s, logic last);
    particle_result_t r;
    r.kind  = k;
    r.slot  = 6'(s);
    r.pos_x = pool_pos_x[s];
    r.pos_y = pool_pos_y[s];
    r.vel_x = pool_vel_x[s];
    r.vel_y = pool_vel_y[s];
    r.size  = pool_size[s];
    r.rgba  = pool_rgba[s];
    r.life  = pool_life[s];
    r.last  = last;
    return r;
  endfunction

  function automatic particle_result_t blank_result(kind_t k);
    particle_result_t r;
    r.kind  = k;
    r.slot  = '0;
    r.pos_x = '0;
    r.pos_y = '0;
    r.vel_x = '0;
    r.vel_y = '0;
    r.size  = '0;
    r.rgba  = '0;
    r.life  = '0;
    r.last  = 1'b1;
    return r;
  endfunction

  task automatic model_request(input request_t r);
    int unsigned slot;
    int unsigned live;
    logic        found;
    logic [31:0] loss;
    slot  = 0;
    live  = 0;
    found = 1'b0;
    case (r.cmd)
      CMD_ADD: begin
        for (int n = 0; n < SLOT_COUNT; n++) begin
          if (!found && pool_life[(next_fit_pos + n) % SLOT_COUNT] == '0) begin
            slot  = (next_fit_pos + n) % SLOT_COUNT;
            found = 1'b1;
          end
        end
        // full pool: slot 0 is overwritten, search position kept
        if (found) next_fit_pos = slot;
        pool_pos_x[slot] = r.pos_x;
        pool_pos_y[slot] = r.pos_y;
        pool_vel_x[slot] = r.vel_x;
        pool_vel_y[slot] = r.vel_y;
        pool_rgba[slot]  = r.rgba;
        pool_size[slot]  = r.size;
        pool_life[slot]  = LIFE_FULL;
        expected_results.push_back(slot_record(KIND_ASSIGNED, slot, 1'b1));
      end
      CMD_TICK: begin
        loss = (32'(decay_rate_now) * 32'(r.delta_time)) >> LOSS_SHIFT;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (pool_life[i] != '0) begin
            pool_life[i] = (loss >= 32'(pool_life[i])) ? '0 : pool_life[i] - 16'(loss);
          end
        end
        expected_results.push_back(blank_result(KIND_TICK));
      end
      CMD_LIST: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (pool_life[i] != '0) begin
            expected_results.push_back(slot_record(KIND_LIVE, i, 1'b0));
            live++;
          end
        end
        if (live == 0) begin
          expected_results.push_back(blank_result(KIND_NONE));
        end else begin
          expected_results[expected_results.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  function automatic request_t random_request(int unsigned add_pct);
    request_t    r;
    int unsigned pick;
    r.pos_x = $urandom;
    r.pos_y = $urandom;
    r.vel_x = $urandom;
    r.vel_y = $urandom;
    r.rgba  = $urandom;
    r.size  = $urandom;
    case ($urandom_range(0, 4))
      0:       r.delta_time = '0;
      1:       r.delta_time = 16'hffff;
      2:       r.delta_time = 16'($urandom_range(0, 63));
      3:       r.delta_time = 16'($urandom_range(0, 1023));
      default: r.delta_time = 16'($urandom);
    endcase
    if ($urandom_range(0, 99) < add_pct) begin
      r.cmd = CMD_ADD;
    end else begin
      pick  = $urandom_range(0, 19);
      r.cmd = (pick < 9) ? CMD_TICK : (pick < 18) ? CMD_LIST : CMD_IGNORED;
    end
    return r;
  endfunction

  task automatic push_request(input request_t r);
    pending_reqs.push_back(r);
    issued_count++;
  endtask

  task automatic push_cmd(input logic [1:0] cmd, input logic [15:0] dt);
    request_t r;
    r            = random_request(0);
    r.cmd        = cmd;
    r.delta_time = dt;
    push_request(r);
  endtask

  task automatic push_add(input logic [31:0] px, input logic [31:0] py,
                          input logic [31:0] vx, input logic [31:0] vy,
                          input logic [31:0] rgba, input logic [31:0] size);
    request_t r;
    r       = random_request(100);
    r.pos_x = px;
    r.pos_y = py;
    r.vel_x = vx;
    r.vel_y = vy;
    r.rgba  = rgba;
    r.size  = size;
    push_request(r);
  endtask

  task automatic write_decay_rate(input logic [15:0] rate);
    @(negedge clk);
    cfg_we         = 1'b1;
    cfg_wdata      = rate;
    decay_rate_now = rate;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic settle();
    while (accepted_count != issued_count || expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : request_accept
    if (!rst && req_ch.valid && req_ch.ready) begin
      model_request(req_item);
      accepted_count++;
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : request_drive
    if (!req_ch.valid || req_taken) begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_item = pending_reqs.pop_front();
        req_ch.command    <= req_item.cmd;
        req_ch.pos_x      <= req_item.pos_x;
        req_ch.pos_y      <= req_item.pos_y;
        req_ch.vel_x      <= req_item.vel_x;
        req_ch.vel_y      <= req_item.vel_y;
        req_ch.rgba       <= req_item.rgba;
        req_ch.size       <= req_item.size;
        req_ch.delta_time <= req_item.delta_time;
        req_ch.valid      <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(negedge clk) begin : result_stall
    if (mode_left == 0) begin
      mode_left = $urandom_range(100, 400);
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        default: stall_pct = 50;
      endcase
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      resp_ch.ready <= 1'b0;
    end else begin
      resp_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin : result_check
    particle_result_t want;
    if (!rst && resp_ch.valid && resp_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result expected none actual kind %0d slot %0d last %0b",
                 $time, resp_ch.kind, resp_ch.slot, resp_ch.last);
      end else begin
        want = expected_results.pop_front();
        compare_field("kind", 32'(want.kind), 32'(resp_ch.kind));
        compare_field("slot", 32'(want.slot), 32'(resp_ch.slot));
        compare_field("out_pos_x", want.pos_x, resp_ch.out_pos_x);
        compare_field("out_pos_y", want.pos_y, resp_ch.out_pos_y);
        compare_field("out_vel_x", want.vel_x, resp_ch.out_vel_x);
        compare_field("out_vel_y", want.vel_y, resp_ch.out_vel_y);
        compare_field("out_size", want.size, resp_ch.out_size);
        compare_field("out_rgba", want.rgba, resp_ch.out_rgba);
        compare_field("life_left", 32'(want.life), 32'(resp_ch.life_left));
        compare_field("last", 32'(want.last), 32'(resp_ch.last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_ADD;
    req_ch.pos_x       = '0;
    req_ch.pos_y       = '0;
    req_ch.vel_x       = '0;
    req_ch.vel_y       = '0;
    req_ch.rgba        = '0;
    req_ch.size        = '0;
    req_ch.delta_time  = '0;
    resp_ch.ready      = 1'b0;
    decay_rate_now     = RATE_RESET;
    next_fit_pos       = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pool_life[i]  = '0;
      pool_pos_x[i] = '0;
      pool_pos_y[i] = '0;
      pool_vel_x[i] = '0;
      pool_vel_y[i] = '0;
      pool_rgba[i]  = '0;
      pool_size[i]  = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty pool, field extremes, exact and saturating decay
    push_cmd(CMD_LIST, 16'h0000);
    push_cmd(CMD_TICK, 16'hffff);
    push_cmd(CMD_IGNORED, 16'hffff);
    push_add(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h00000000,
             32'hffffffff, 32'h00000000);
    push_add(32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff,
             32'h00000000, 32'hffffffff);
    push_add(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
             32'h12345678, 32'h00010000);
    push_cmd(CMD_LIST, 16'h0000);
    push_cmd(CMD_TICK, 16'h0000);
    push_cmd(CMD_TICK, 16'hffff);
    push_cmd(CMD_LIST, 16'h0000);
    push_cmd(CMD_TICK, 16'd2);
    push_cmd(CMD_LIST, 16'h0000);
    repeat (3) push_request(random_request(100));
    push_cmd(CMD_TICK, 16'd1000);
    push_cmd(CMD_LIST, 16'h0000);
    push_cmd(CMD_TICK, 16'hffff);
    push_cmd(CMD_LIST, 16'h0000);
    push_request(random_request(100));
    push_cmd(CMD_LIST, 16'h0000);
    settle();

    // no decay: fill the pool and overflow it
    write_decay_rate(16'h0000);
    repeat (34) push_request(random_request(100));
    push_cmd(CMD_TICK, 16'hffff);
    push_cmd(CMD_LIST, 16'h0000);
    settle();

    write_decay_rate(16'hffff);
    repeat (30) push_request(random_request(50));
    settle();

    write_decay_rate(16'($urandom_range(1, 65534)));
    repeat (20) push_request(random_request(50));
    settle();

    write_decay_rate(RATE_RESET);
    repeat (30) push_request(random_request(40));
    settle();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
